// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/fwpid_pkg.sv =====
// shared constants and types for the four wheel pid speed controller
// no dependencies
package fwpid_pkg;
    localparam int unsigned WHEELS_DEF        = 4;
    localparam longint      SPEED_SCALE_DEF   = 65536;
    localparam longint      HALF_BASE_SUM_DEF = 65536;
    localparam longint      TIME_FACTOR       = 10000;
    localparam int          SMALL_PWM         = 50;

    localparam logic [2:0] REG_VX    = 3'd0;
    localparam logic [2:0] REG_VY    = 3'd1;
    localparam logic [2:0] REG_TURN  = 3'd2;
    localparam logic [2:0] REG_KP    = 3'd3;
    localparam logic [2:0] REG_KI    = 3'd4;
    localparam logic [2:0] REG_KD    = 3'd5;
    localparam logic [2:0] REG_IBND  = 3'd6;
    localparam logic [2:0] REG_OBND  = 3'd7;

    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_FWD  = 2'd1;
    localparam logic [1:0] DRV_BACK = 2'd2;

    // one state memory entry
    typedef struct packed {
        logic signed [31:0] sum;
        logic signed [31:0] prev_err;
    } t_wstate;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [31:0] divisor;
    } t_div_req;
endpackage

// ===== rtl/fwpid_div.sv =====
// restoring divider, one quotient bit per cycle
// uses fwpid_pkg
module fwpid_div
    import fwpid_pkg::*;
#(
    parameter int NW = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_div_req      i_req,
    input  logic [NW-1:0] i_dividend,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q, n_q;
    logic [32:0]   r_rem, n_rem;
    logic [31:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [32:0]   sh;

    always_comb begin
        sh    = {r_rem[31:0], r_q[NW-1]};
        n_q   = {r_q[NW-2:0], 1'b0};
        n_rem = sh;
        if (sh >= {1'b0, r_den}) begin
            n_rem = sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== rtl/four_wheel_pid_speed_control.sv =====
// top level of the four wheel pid speed controller
// uses fwpid_pkg, fwpid_div and assert_macros.svh
//
// input channel: one word per wheel update (wheel, timer now, two capture
// times, spin sign), valid/stall handshake. output channel: one word per
// input word (wheel, duty, drive code, measured speed), valid/stall.
// after the accepting edge the word passes the bit-serial speed divider
// (its 64 quotient bits and its done flag), then the state memory read,
// setpoint, error, the three gain products (integral clamp beside the
// first), the output clamp with the write back, and the output register
// load, before o_valid. one word is in work at a time, so no new word is
// taken until the last has reached the output register; the next is taken
// while the result sits in the output register, even if the receiver
// stalls, and that register holds steady under stall; a finished word
// then waits for it to drain, and the input stalls meanwhile.
// state (error sum and previous error per wheel) sits in one synchronous
// memory with a registered read; after reset a clearing pass zeros each
// entry in turn, during which no word is taken.
// configuration writes go straight to registers and should be made idle.
// wheel numbers at or beyond WHEELS report speed but leave state alone.
`include "assert_macros.svh"
module four_wheel_pid_speed_control
    import fwpid_pkg::*;
#(
    parameter int unsigned WHEELS        = WHEELS_DEF,
    parameter longint      SPEED_SCALE   = SPEED_SCALE_DEF,
    parameter longint      HALF_BASE_SUM = HALF_BASE_SUM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_wheel_index,
    input  logic [31:0]        i_time_now,
    input  logic [31:0]        i_capture_last,
    input  logic [31:0]        i_capture_prev,
    input  logic signed [1:0]  i_spin_sign,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_wheel_out,
    output logic [15:0]        o_duty,
    output logic [1:0]         o_drive_code,
    output logic signed [31:0] o_speed_measured,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int AW = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam logic [63:0] NUMER = 64'(SPEED_SCALE * TIME_FACTOR);

    // state codes
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_SETP = 4'd4;
    localparam logic [3:0] S_ERR  = 4'd5;
    localparam logic [3:0] S_MP   = 4'd6;
    localparam logic [3:0] S_MI   = 4'd7;
    localparam logic [3:0] S_MD   = 4'd8;
    localparam logic [3:0] S_PWM  = 4'd9;
    localparam logic [3:0] S_WB   = 4'd10;

    // configuration registers
    logic signed [31:0] r_vx, r_vy, r_turn;
    logic [15:0]        r_kp, r_ki, r_kd, r_obnd;
    logic [30:0]        r_ibnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= '0; r_vy <= '0; r_turn <= '0;
            r_kp <= '0; r_ki <= '0; r_kd <= '0;
            r_ibnd <= '0; r_obnd <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VX:   r_vx   <= i_cfg_data;
                REG_VY:   r_vy   <= i_cfg_data;
                REG_TURN: r_turn <= i_cfg_data;
                REG_KP:   r_kp   <= i_cfg_data[15:0];
                REG_KI:   r_ki   <= i_cfg_data[15:0];
                REG_KD:   r_kd   <= i_cfg_data[15:0];
                REG_IBND: r_ibnd <= i_cfg_data[30:0];
                REG_OBND: r_obnd <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // state memory
    t_wstate mem [WHEELS];
    t_wstate r_rd;
    logic    mem_we;
    logic [AW-1:0] mem_wa;
    t_wstate mem_wd;

    logic [3:0]  r_st;
    logic [AW:0] r_clr;
    logic [1:0]  r_w;
    logic [1:0]  r_sgn;
    logic        r_inr;
    logic signed [31:0] r_speed, r_setp, r_err, r_sum;
    logic signed [47:0] r_turnt;
    logic signed [63:0] r_acc;
    logic               r_ov;
    logic [1:0]  r_ow, r_oc, r_pc;
    logic [15:0] r_od, r_pd;
    logic signed [31:0] r_osp;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[AW'(r_w)];
    end

    // divider
    t_div_req    dreq;
    logic        ddone;
    logic [63:0] dq;
    fwpid_div #(.NW(64)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .i_dividend(NUMER),
        .o_done(ddone), .o_quot(dq)
    );

    logic        accept;
    logic [31:0] d1, d2, per;
    assign o_stall = (r_st != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign d1  = i_time_now - i_capture_last;
    assign d2  = i_capture_last - i_capture_prev;
    assign per = (d1 > d2) ? d1 : d2;
    assign dreq.start   = accept;
    assign dreq.divisor = (per == '0) ? 32'd1 : per;

    // combinational pieces of each step
    logic signed [31:0] spd;
    logic signed [49:0] sp_sum;
    logic signed [33:0] e_full;
    logic signed [33:0] s_full;
    logic signed [32:0] ibnd;
    logic signed [32:0] deriv;
    logic signed [63:0] pwm_q;
    logic signed [63:0] pwm_c;
    logic signed [63:0] obnd_s;
    logic               pwm_low;
    logic signed [50:0] prod;

    always_comb begin
        if (r_sgn == 2'b01)
            spd = (dq > 64'd2147483647) ? 32'sh7FFFFFFF : 32'(dq);
        else if (r_sgn[1])
            spd = (dq > 64'd2147483648) ? 32'sh80000000 : 32'(-dq);
        else
            spd = '0;
        sp_sum = 50'(r_vx) + (r_w[0] ? 50'(r_vy) : -50'(r_vy))
               + (r_w[1] ? -50'(r_turnt) : 50'(r_turnt));
        e_full = 34'(r_setp) - 34'(r_speed);
        ibnd   = 33'({2'b0, r_ibnd});
        s_full = 34'(r_rd.sum) + 34'(r_err);
        deriv  = 33'(r_err) - 33'(r_rd.prev_err);
        pwm_q  = (r_acc < 0) ? -((-r_acc) >>> 24) : (r_acc >>> 24);
        obnd_s = 64'($signed({1'b0, r_obnd}));
        pwm_c  = pwm_q;
        if (pwm_q > obnd_s) pwm_c = obnd_s;
        if (pwm_q < -obnd_s) pwm_c = -obnd_s;
        pwm_low = (pwm_c < 64'(SMALL_PWM)) && (pwm_c > -64'(SMALL_PWM));
        case (r_st)
            S_MP:    prod = $signed({1'b0, r_kp}) * 35'(r_err);
            S_MI:    prod = $signed({1'b0, r_ki}) * 35'(r_sum);
            default: prod = $signed({1'b0, r_kd}) * 35'(deriv);
        endcase
        mem_we = 1'b0;
        mem_wa = AW'(r_w);
        mem_wd.sum      = pwm_low ? 32'sd0 : r_sum;
        mem_wd.prev_err = r_err;
        if (r_st == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr[AW-1:0];
            mem_wd = '0;
        end else if (r_st == S_PWM && r_inr) begin
            mem_we = 1'b1;
        end
    end

    logic signed [65:0] tprod;
    assign tprod = 66'(r_turn) * 66'(HALF_BASE_SUM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_clr <= '0;
            r_ov  <= 1'b0;
        end else begin
            // output register: load from write back, drop once taken
            if (r_st == S_WB && !(r_ov && i_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(WHEELS - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (accept) begin
                    r_st  <= S_DIV;
                    r_w   <= i_wheel_index;
                    r_sgn <= i_spin_sign;
                    r_inr <= 32'(i_wheel_index) < WHEELS;
                end
                S_DIV: if (ddone) begin
                    r_speed <= spd;
                    r_turnt <= 48'(tprod / 66'sd65536);
                    r_st    <= r_inr ? S_RD : S_WB;
                end
                S_RD:   r_st <= S_SETP;
                S_SETP: begin
                    r_setp <= (sp_sum > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                              (sp_sum < -50'sh80000000) ? 32'sh80000000 : 32'(sp_sum);
                    r_st <= S_ERR;
                end
                S_ERR: begin
                    r_err <= (e_full > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                             (e_full < -34'sh80000000) ? 32'sh80000000 : 32'(e_full);
                    r_st <= S_MP;
                end
                S_MP: begin
                    r_sum <= (s_full > 34'(ibnd)) ? 32'(ibnd) :
                             (s_full < -34'(ibnd)) ? 32'(-ibnd) : 32'(s_full);
                    r_acc <= 64'(prod);
                    r_st  <= S_MI;
                end
                S_MI: begin r_acc <= r_acc + 64'(prod); r_st <= S_MD; end
                S_MD: begin r_acc <= r_acc + 64'(prod); r_st <= S_PWM; end
                S_PWM: begin
                    r_pd <= (pwm_c < 0) ? 16'(-pwm_c) : 16'(pwm_c);
                    r_pc <= (pwm_c > 0) ? DRV_FWD : (pwm_c < 0) ? DRV_BACK : DRV_STOP;
                    r_st <= S_WB;
                end
                S_WB: if (!(r_ov && i_stall)) begin
                    r_ow  <= r_w;
                    r_osp <= r_speed;
                    r_od  <= r_inr ? r_pd : 16'd0;
                    r_oc  <= r_inr ? r_pc : DRV_STOP;
                    r_st  <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_wheel_out      = r_ow;
    assign o_duty           = r_od;
    assign o_drive_code     = r_oc;
    assign o_speed_measured = r_osp;

    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, r_st != S_IDLE, o_stall)
    `ASSERT_NEXT(a_accept_div, i_clk, i_rst_n, accept, r_st == S_DIV)
    `ASSERT_IMPL(a_code_duty, i_clk, i_rst_n, r_ov, (r_oc == DRV_STOP) == (r_od == 16'd0))
endmodule
